/* design/pdc_pkg.sv */
// Shared types, codes and saturating helpers for the position/delta PID controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_POS  = 2'd0,
    MODE_INC  = 2'd1,
    MODE_RATE = 2'd2
  } ctrl_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL_MODE    = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_INTEG_LIMIT  = 3'd4,
    REG_OUTPUT_LIMIT = 3'd5,
    REG_ERR_CEILING  = 3'd6,
    REG_DEAD_ZONE    = 3'd7
  } cfg_reg_e;

  localparam logic REQ_COMPUTE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  typedef struct packed {
    logic [1:0]               ctrl_mode;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIM_W-1:0]         integ_limit;
    logic [LIM_W-1:0]         output_limit;
    logic [LIM_W-1:0]         err_ceiling;
    logic [LIM_W-1:0]         dead_zone;
  } cfg_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] rate_meas;
  } item_t;

  localparam logic signed [34:0] SAT_MAX35 = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN35 = -35'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX35) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN35) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [34:0] ext35(input logic signed [31:0] v);
    return $signed({{3{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] clampm(input logic signed [31:0] v,
                                                input logic [LIM_W-1:0] lim);
    logic signed [31:0] lp;
    logic signed [31:0] ln;
    logic signed [31:0] r;
    lp = $signed({1'b0, lim});
    ln = -lp;
    if (v > lp) begin
      r = lp;
    end else if (v < ln) begin
      r = ln;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/pdc_cfg_regs.sv */
// Configuration register file: mode, gains, limits and error window.
// Depends on pdc_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module pdc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pdc_pkg::DATA_W-1:0]     cfg_data_i,
  output pdc_pkg::cfg_t                       cfg_o
);
  import pdc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CTRL_MODE:    cfg_d.ctrl_mode    = cfg_data_i[1:0];
        REG_GAIN_P:       cfg_d.gain_p       = $signed(cfg_data_i);
        REG_GAIN_I:       cfg_d.gain_i       = $signed(cfg_data_i);
        REG_GAIN_D:       cfg_d.gain_d       = $signed(cfg_data_i);
        REG_INTEG_LIMIT:  cfg_d.integ_limit  = cfg_data_i[LIM_W-1:0];
        REG_OUTPUT_LIMIT: cfg_d.output_limit = cfg_data_i[LIM_W-1:0];
        REG_ERR_CEILING:  cfg_d.err_ceiling  = cfg_data_i[LIM_W-1:0];
        REG_DEAD_ZONE:    cfg_d.dead_zone    = cfg_data_i[LIM_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/pdc_mulq.sv */
// Fixed-point multiply: full product, arithmetic shift by FracBits, saturate to 32 bits.
// Depends on pdc_pkg for the data width.
`default_nettype none

module pdc_mulq #(
  parameter int unsigned FracBits = pdc_pkg::FRAC_BITS
) (
  input  wire logic signed [pdc_pkg::DATA_W-1:0] a_i,
  input  wire logic signed [pdc_pkg::DATA_W-1:0] b_i,
  output logic signed [pdc_pkg::DATA_W-1:0]      y_o
);
  import pdc_pkg::*;

  localparam int unsigned ProdW = 2 * DATA_W;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] shifted;
  logic                    ovf_pos;
  logic                    ovf_neg;

  assign prod    = a_i * b_i;
  assign shifted = prod >>> FracBits;
  assign ovf_pos = !shifted[ProdW-1] && (shifted[ProdW-2:DATA_W-1] != '0);
  assign ovf_neg = shifted[ProdW-1] && (shifted[ProdW-2:DATA_W-1] != '1);

  always_comb begin
    if (ovf_pos) begin
      y_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (ovf_neg) begin
      y_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_o = shifted[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/pdc_datapath.sv */
// Control law and controller state: error, error window, P/I/D terms, clamps.
// Depends on pdc_pkg and pdc_mulq; state advances on step_en_i.
`default_nettype none

module pdc_datapath #(
  parameter int unsigned FracBits = pdc_pkg::FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pdc_pkg::cfg_t                     cfg_i,
  input  wire pdc_pkg::item_t                    item_i,
  input  wire logic                              step_en_i,
  output logic signed [pdc_pkg::DATA_W-1:0]      drive_o,
  output logic                                   suppressed_o
);
  import pdc_pkg::*;

  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] prev_q, prev_d;
  logic signed [31:0] pprev_q, pprev_d;
  logic signed [31:0] incr_q, incr_d;

  logic signed [34:0] err_wide;
  logic signed [31:0] err;
  logic [31:0]        err_mag;
  logic signed [31:0] diff1;
  logic signed [31:0] diff2;
  logic signed [31:0] op_p, op_d_b;
  logic signed [31:0] prod_p, prod_i, prod_d;
  logic signed [31:0] integ_pos;
  logic signed [31:0] drive_pos;
  logic signed [31:0] it_inc;
  logic signed [31:0] sum_inc;
  logic signed [31:0] incr_new;
  logic               hit_window;
  logic               is_inc;
  logic               is_rate;

  assign is_inc  = (cfg_i.ctrl_mode == MODE_INC);
  assign is_rate = (cfg_i.ctrl_mode == MODE_RATE);

  assign err_wide = ext35(item_i.target) - ext35(item_i.measured);
  assign err      = sat32(err_wide);
  assign err_mag  = err[31] ? (~err + 32'd1) : err;

  assign hit_window = ((cfg_i.err_ceiling != '0) && (err_mag > {1'b0, cfg_i.err_ceiling})) ||
                      ((cfg_i.dead_zone != '0) && (err_mag < {1'b0, cfg_i.dead_zone}));

  assign diff1 = sat32(ext35(err) - ext35(prev_q));
  assign diff2 = sat32(ext35(err) - (ext35(prev_q) <<< 1) + ext35(pprev_q));

  assign op_p   = is_inc ? diff1 : err;
  assign op_d_b = is_rate ? item_i.rate_meas : (is_inc ? diff2 : diff1);

  pdc_mulq #(.FracBits(FracBits)) u_mul_p (.a_i(cfg_i.gain_p), .b_i(op_p),   .y_o(prod_p));
  pdc_mulq #(.FracBits(FracBits)) u_mul_i (.a_i(cfg_i.gain_i), .b_i(err),    .y_o(prod_i));
  pdc_mulq #(.FracBits(FracBits)) u_mul_d (.a_i(cfg_i.gain_d), .b_i(op_d_b), .y_o(prod_d));

  assign integ_pos = clampm(sat32(ext35(integ_q) + ext35(prod_i)), cfg_i.integ_limit);
  assign drive_pos = clampm(sat32(ext35(prod_p) + ext35(integ_pos) + ext35(prod_d)),
                            cfg_i.output_limit);

  assign it_inc   = clampm(prod_i, cfg_i.integ_limit);
  assign sum_inc  = sat32(ext35(prod_p) + ext35(it_inc) + ext35(prod_d));
  assign incr_new = clampm(sat32(ext35(incr_q) + ext35(sum_inc)), cfg_i.output_limit);

  always_comb begin
    integ_d      = integ_q;
    prev_d       = prev_q;
    pprev_d      = pprev_q;
    incr_d       = incr_q;
    drive_o      = '0;
    suppressed_o = 1'b0;
    if (item_i.req_type == REQ_CLEAR) begin
      integ_d = '0;
    end else if (is_rate) begin
      integ_d = integ_pos;
      drive_o = drive_pos;
    end else if (hit_window) begin
      suppressed_o = 1'b1;
    end else if (is_inc) begin
      integ_d = it_inc;
      incr_d  = incr_new;
      drive_o = incr_new;
      pprev_d = prev_q;
      prev_d  = err;
    end else begin
      integ_d = integ_pos;
      drive_o = drive_pos;
      pprev_d = prev_q;
      prev_d  = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      pprev_q <= '0;
      incr_q  <= '0;
    end else if (step_en_i) begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
      pprev_q <= pprev_d;
      incr_q  <= incr_d;
    end
  end

endmodule

`default_nettype wire

/* design/pid_position_delta_controller_top.sv */
// PID controller top: input register, single-pass control law, result register.
// A request beat is held in the input register, its result in the result register;
// one request per cycle unless out_stall_i holds a result. The state feedback closes
// within the one combinational pass between input and result registers.
// Reset (async, active low) clears all configuration and controller state to zero.
`default_nettype none

module pid_position_delta_controller_top #(
  parameter int unsigned FRAC_BITS = pdc_pkg::FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              req_type_i,
  input  wire logic signed [pdc_pkg::DATA_W-1:0] measured_i,
  input  wire logic signed [pdc_pkg::DATA_W-1:0] target_i,
  input  wire logic signed [pdc_pkg::DATA_W-1:0] rate_meas_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [pdc_pkg::DATA_W-1:0]      drive_o,
  output logic                                   suppressed_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdc_pkg::DATA_W-1:0]        cfg_data_i
);
  import pdc_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q, in_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  advance;
  logic  in_accept;
  logic signed [DATA_W-1:0] drive_d, drive_q;
  logic  suppressed_d, suppressed_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  pdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pdc_datapath #(.FracBits(FRAC_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item_q),
    .step_en_i    (in_valid_q && advance),
    .drive_o      (drive_d),
    .suppressed_o (suppressed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req_type  <= req_type_i;
      item_q.measured  <= measured_i;
      item_q.target    <= target_i;
      item_q.rate_meas <= rate_meas_i;
    end
    if (in_valid_q && advance) begin
      drive_q      <= drive_d;
      suppressed_q <= suppressed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_o      = drive_q;
  assign suppressed_o = suppressed_q;

endmodule

`default_nettype wire

/* bench/tb_pid_position_delta_controller_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for pid_position_delta_controller_top: a queue-fed driver, a stall
// pattern on the result side and a fixed-point predictor that scores every result beat.
// Depends on pdc_pkg and the controller RTL only.

module tb_pid_position_delta_controller_top;
  import pdc_pkg::*;

  localparam int CYCLE_NS     = 12;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 125;
  localparam int RAND_PHASES  = 12;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               suppressed;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = REQ_COMPUTE;
  logic signed [DATA_W-1:0] measured_i = '0;
  logic signed [DATA_W-1:0] target_i = '0;
  logic signed [DATA_W-1:0] rate_meas_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic suppressed_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_CTRL_MODE;
  logic [DATA_W-1:0] cfg_data_i = '0;

  pid_position_delta_controller_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .measured_i   (measured_i),
    .target_i     (target_i),
    .rate_meas_i  (rate_meas_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o),
    .suppressed_o (suppressed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #(CYCLE_NS / 2) clk_i = 1'b1;
    #(CYCLE_NS / 2) clk_i = 1'b0;
  end

  // predictor copy of configuration and controller state
  logic [1:0]         cfg_mode;
  logic signed [31:0] kp, ki, kd;
  logic [30:0]        integ_lim, drive_lim, err_max, err_min;
  logic signed [31:0] integ_sum, err_prev, err_prev2, pos_drive, inc_drive;

  item_t         pending_q[$];
  drive_result_t drive_due_q[$];
  item_t         next_beat;
  drive_result_t predicted;
  drive_result_t want;

  int n_items, n_clears, n_results, n_suppressed, n_settings, mismatches;
  int burst_left, gap_left;
  int hold_left, seg_left, stall_pct;
  bit hold_req, hold_seen;

  logic [1:0] mode_seq [4] = '{MODE_POS, MODE_INC, MODE_RATE, MODE_SPARE};

  function automatic logic signed [63:0] x64(input logic signed [31:0] v);
    return v;
  endfunction

  function automatic logic signed [63:0] x64u(input logic [30:0] v);
    return {33'd0, v};
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > x64(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < x64(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = x64(a) * x64(b);
    return sat_q(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] lim_q(input logic signed [31:0] v,
                                               input logic [30:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = x64u(lim);
    lo = -hi;
    if (x64(v) > hi) return hi[31:0];
    if (x64(v) < lo) return lo[31:0];
    return v;
  endfunction

  function automatic drive_result_t pid_step(input item_t beat);
    drive_result_t r;
    logic signed [31:0] e, pt, it_term, dt;
    logic signed [63:0] mag;
    r.drive = '0;
    r.suppressed = 1'b0;
    if (beat.req_type == REQ_CLEAR) begin
      integ_sum = '0;
      pos_drive = '0;
      return r;
    end
    e = sat_q(x64(beat.target) - x64(beat.measured));
    mag = (e < 0) ? -x64(e) : x64(e);
    if (cfg_mode == MODE_RATE) begin
      pt = q_mul(kp, e);
      integ_sum = lim_q(sat_q(x64(integ_sum) + x64(q_mul(ki, e))), integ_lim);
      dt = q_mul(kd, beat.rate_meas);
      pos_drive = lim_q(sat_q(x64(pt) + x64(integ_sum) + x64(dt)), drive_lim);
      r.drive = pos_drive;
      return r;
    end
    if ((err_max != 0 && mag > x64u(err_max)) || (err_min != 0 && mag < x64u(err_min))) begin
      r.suppressed = 1'b1;
      return r;
    end
    if (cfg_mode == MODE_INC) begin
      pt = q_mul(kp, sat_q(x64(e) - x64(err_prev)));
      it_term = lim_q(q_mul(ki, e), integ_lim);
      integ_sum = it_term;
      dt = q_mul(kd, sat_q(x64(e) - 2 * x64(err_prev) + x64(err_prev2)));
      inc_drive = lim_q(sat_q(x64(inc_drive) +
                              x64(sat_q(x64(pt) + x64(it_term) + x64(dt)))), drive_lim);
      r.drive = inc_drive;
    end else begin
      pt = q_mul(kp, e);
      integ_sum = lim_q(sat_q(x64(integ_sum) + x64(q_mul(ki, e))), integ_lim);
      dt = q_mul(kd, sat_q(x64(e) - x64(err_prev)));
      pos_drive = lim_q(sat_q(x64(pt) + x64(integ_sum) + x64(dt)), drive_lim);
      r.drive = pos_drive;
    end
    err_prev2 = err_prev;
    err_prev = e;
    return r;
  endfunction

  // driver: bursts of beats separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= REQ_COMPUTE;
      measured_i <= '0;
      target_i <= '0;
      rate_meas_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        next_beat = '{req_type: req_type_i, measured: measured_i,
                      target: target_i, rate_meas: rate_meas_i};
        predicted = pid_step(next_beat);
        drive_due_q.push_back(predicted);
        n_items++;
        if (req_type_i == REQ_CLEAR) n_clears++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_beat = pending_q.pop_front();
        req_type_i <= next_beat.req_type;
        measured_i <= next_beat.measured;
        target_i <= next_beat.target;
        rate_meas_i <= next_beat.rate_meas;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result-side stall pattern, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
      seg_left <= 0;
      stall_pct <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(200, 20);
        case ($urandom_range(3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: score each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (drive_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: drive=%h suppressed=%b", drive_o, suppressed_o);
      end else begin
        want = drive_due_q.pop_front();
        if (want.suppressed) n_suppressed++;
        if (drive_o !== want.drive || suppressed_o !== want.suppressed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: drive exp %h got %h, suppressed exp %b got %b",
                     n_results, want.drive, drive_o, want.suppressed, suppressed_o);
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CTRL_MODE:    cfg_mode = val[1:0];
      REG_GAIN_P:       kp = val;
      REG_GAIN_I:       ki = val;
      REG_GAIN_D:       kd = val;
      REG_INTEG_LIMIT:  integ_lim = val[30:0];
      REG_OUTPUT_LIMIT: drive_lim = val[30:0];
      REG_ERR_CEILING:  err_max = val[30:0];
      default:          err_min = val[30:0];
    endcase
  endtask

  task automatic set_regs(input logic [1:0] mode, input logic [31:0] p, i, d,
                          input logic [31:0] il, ol, ec, dz);
    @(posedge clk_i);
    write_reg(REG_CTRL_MODE, {30'd0, mode});
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_INTEG_LIMIT, il);
    write_reg(REG_OUTPUT_LIMIT, ol);
    write_reg(REG_ERR_CEILING, ec);
    write_reg(REG_DEAD_ZONE, dz);
    cfg_valid_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || drive_due_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_item(input logic req, input logic [31:0] m, t, r);
    pending_q.push_back(item_t'{req_type: req, measured: m, target: t, rate_meas: r});
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'h0;
      default: return $urandom_range(32'h8_0000) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_lim();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return ($urandom_range(1) << 31) | $urandom_range(32'h200_0000, 32'h1_0000);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t b;
    logic [31:0] delta;
    b.req_type = ($urandom_range(24) == 0) ? REQ_CLEAR : REQ_COMPUTE;
    b.rate_meas = ($urandom_range(2) == 0) ? $urandom : $urandom_range(32'h8_0000) - 32'h4_0000;
    case ($urandom_range(9))
      0: begin
        b.measured = $urandom;
        b.target = $urandom;
      end
      1: begin
        b.measured = $urandom;
        b.target = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: begin
        b.measured = $urandom_range(32'h20_0000) - 32'h10_0000;
        delta = $urandom_range(1) ? ($urandom_range(32'h4_0000) - 32'h2_0000)
                                  : ($urandom_range(32'h100_0000) - 32'h80_0000);
        b.target = b.measured + delta;
      end
    endcase
    return b;
  endfunction

  initial begin
    cfg_mode = MODE_POS;
    {kp, ki, kd} = '0;
    {integ_lim, drive_lim, err_max, err_min} = '0;
    {integ_sum, err_prev, err_prev2, pos_drive, inc_drive} = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset configuration: all gains and limits zero
    push_item(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_idle();

    set_regs(MODE_POS, 32'h1_0000, 32'h8000, 32'h4000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    push_item(REQ_COMPUTE, 32'h0, 32'h1_0000, 32'h0);
    push_item(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    push_item(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(REQ_COMPUTE, 32'h0, 32'hFFFE_0000, 32'h0);
    wait_idle();

    set_regs(MODE_INC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_0000, 32'h7FFF_FFFF,
             32'h10_0000, 32'h1000);
    push_item(REQ_COMPUTE, 32'h0, 32'h8000, 32'h0);
    push_item(REQ_COMPUTE, 32'h0, 32'h800, 32'h0);
    push_item(REQ_COMPUTE, 32'h0, 32'h20_0000, 32'h0);
    push_item(REQ_COMPUTE, 32'h0, 32'h1000, 32'h0);
    push_item(REQ_COMPUTE, 32'h0, 32'h10_0000, 32'h0);
    push_item(REQ_COMPUTE, 32'h8000, 32'h0, 32'h0);
    push_item(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
    push_item(REQ_COMPUTE, 32'h1234_5678, 32'h1234_9678, 32'h0);
    wait_idle();

    set_regs(MODE_RATE, 32'h2_0000, 32'h1_0000, 32'h7FFF_FFFF, 32'h4_0000, 32'h5_0000,
             32'h100, 32'h8010_0000);
    push_item(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(REQ_COMPUTE, 32'h0, 32'h1, 32'h8000_0000);
    push_item(REQ_COMPUTE, 32'h10, 32'h0, 32'h0);
    push_item(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
    wait_idle();

    set_regs(MODE_SPARE, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0);
    push_item(REQ_COMPUTE, 32'h0, 32'h7FFF_FFFF, 32'h0);
    push_item(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h0, 32'h0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_regs(mode_seq[ph % 4], rand_gain(), rand_gain(), rand_gain(), rand_lim(), rand_lim(),
               ($urandom_range(1) == 0) ? 32'h0
                 : ($urandom_range(1) << 31) | $urandom_range(32'h40_0000, 32'h8000),
               ($urandom_range(1) == 0) ? 32'h0
                 : ($urandom_range(1) << 31) | $urandom_range(32'h2_0000, 32'h100));
      for (int k = 0; k < PHASE_ITEMS; k++) pending_q.push_back(rand_item());
      if (ph == 2) hold_req = ~hold_req;
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d requests (%0d clears) across %0d register settings", n_items,
             n_clears, n_settings);
    $display("checked %0d result beats, %0d suppressed, %0d mismatches", n_results,
             n_suppressed, mismatches);
    if (mismatches == 0 && drive_due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(CYCLE_NS * 600000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
